// ----- rtl/troubled_cell_indicator_macros.svh -----
// Assertion macros for the troubled cell indicator checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TROUBLED_CELL_INDICATOR_MACROS_SVH
`define TROUBLED_CELL_INDICATOR_MACROS_SVH

// Overlapping implication, sampled on clk_i, off during reset.
`define TCI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("troubled_cell_indicator: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TCI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("troubled_cell_indicator: assertion failed");

`endif

// ----- rtl/tci_pkg.sv -----
// Shared types and constants for the troubled cell indicator.
// No dependencies; imported by every module of the block.
`default_nettype none

package tci_pkg;

  localparam int unsigned VALUE_BITS     = 32;
  localparam int unsigned SUM_BITS       = VALUE_BITS + 8;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned CELL_BITS      = 16;
  localparam int unsigned THR_BITS       = 32;
  localparam int unsigned EPS_BITS       = 16;
  localparam int unsigned MPE_BITS       = VALUE_BITS + 1;
  localparam int unsigned PROD_BITS      = THR_BITS + MPE_BITS;
  localparam int unsigned LHS_BITS       = SUM_BITS + FRAC_BITS;
  localparam int unsigned MAX_COMPONENTS = 4;
  localparam int unsigned CFG_IDX_BITS   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EPSILON   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 32'h0001_0000;
  localparam logic [EPS_BITS-1:0] EPSILON_RESET   = 16'h0001;

  // Per-cycle enables from the pipeline control to every lane
  typedef struct packed {
    logic accept;   // element request taken this cycle
    logic first;    // element opens a new stencil
    logic s1_load;  // last element: freeze totals into stage 1
    logic s1_move;  // stage 1 advances to stage 2
    logic s2_move;  // stage 2 advances to stage 3
  } tci_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/tci_lane.sv -----
// One component lane: reference, jump sum and max magnitude accumulators,
// then the threshold multiply and compare. Depends on tci_pkg.
`default_nettype none

module tci_lane
  import tci_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire tci_ctrl_t                    ctrl_i,
  input  wire logic        [THR_BITS-1:0]   threshold_i,
  input  wire logic        [EPS_BITS-1:0]   epsilon_i,
  input  wire logic signed [VALUE_BITS-1:0] center_value_i,
  input  wire logic signed [VALUE_BITS-1:0] own_value_i,
  output logic                              exceed_o
);

  logic [VALUE_BITS-1:0] ref_q, ref_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic [VALUE_BITS-1:0] max_q, max_d;

  logic [VALUE_BITS-1:0] cv_b, ov, om, jump;
  logic [SUM_BITS:0]     sum_ext;
  logic [SUM_BITS-1:0]   sum_sat;

  logic [SUM_BITS-1:0]   s1_sum_q, s2_sum_q, s3_sum_q;
  logic [VALUE_BITS-1:0] s1_max_q;
  logic [MPE_BITS-1:0]   s2_mpe_q;
  logic [PROD_BITS-1:0]  s3_prod_q, prod;

  // Biased center value keeps signed order under unsigned compare
  assign cv_b = {~center_value_i[VALUE_BITS-1], center_value_i[VALUE_BITS-2:0]};

  // Magnitude of own value; most negative value maps to 2^(N-1) exactly
  assign ov = VALUE_BITS'(own_value_i);
  assign om = ov[VALUE_BITS-1] ? VALUE_BITS'(~ov + 1'b1) : ov;

  // Jump from the reference and saturating accumulate
  always_comb begin
    jump    = (ref_q > cv_b) ? (ref_q - cv_b) : (cv_b - ref_q);
    sum_ext = {1'b0, sum_q} + (SUM_BITS + 1)'(jump);
    sum_sat = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
    if (ctrl_i.first) begin
      ref_d = cv_b;
      sum_d = '0;
      max_d = om;
    end else begin
      ref_d = ref_q;
      sum_d = sum_sat;
      max_d = (om > max_q) ? om : max_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      ref_q <= ref_d;
      sum_q <= sum_d;
      max_q <= max_d;
    end
  end

  // Stage 1: totals of the finished stencil
  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_load) begin
      s1_sum_q <= sum_d;
      s1_max_q <= max_d;
    end
  end

  // Stage 2: max + epsilon
  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_move) begin
      s2_sum_q <= s1_sum_q;
      s2_mpe_q <= MPE_BITS'(s1_max_q) + MPE_BITS'(epsilon_i);
    end
  end

  // Stage 3: threshold * (max + epsilon), full width
  assign prod = PROD_BITS'(threshold_i) * PROD_BITS'(s2_mpe_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_move) begin
      s3_sum_q  <= s2_sum_q;
      s3_prod_q <= prod;
    end
  end

  // sum * 2^16 > threshold * (max + epsilon)
  assign exceed_o = PROD_BITS'({s3_sum_q, FRAC_BITS'(0)}) > s3_prod_q;

endmodule

`default_nettype wire

// ----- rtl/tci_merge.sv -----
// Merge stage: ORs the lane verdicts and holds the result payload.
// Depends on tci_pkg.
`default_nettype none

module tci_merge
  import tci_pkg::*;
#(
  parameter int unsigned COMPONENTS = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  load_i,
  input  wire logic [CELL_BITS-1:0]  cell_i,
  input  wire logic [COMPONENTS-1:0] exceed_i,
  output logic      [CELL_BITS-1:0]  result_cell_o,
  output logic                       troubled_o
);

  logic [CELL_BITS-1:0] cell_q;
  logic                 troubled_q;

  // Cell is troubled if any component crossed its threshold
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cell_q     <= cell_i;
      troubled_q <= |exceed_i;
    end
  end

  assign result_cell_o = cell_q;
  assign troubled_o    = troubled_q;

endmodule

`default_nettype wire

// ----- rtl/troubled_cell_indicator.sv -----
// Troubled cell indicator: one element per cycle on the input while in_ready_o
// is high. A four-deep chain of registers (stencil totals, max plus epsilon,
// threshold product, result) sits behind the accumulators and carries the
// result (cell index and troubled flag) once the last_element is accepted;
// each stage moves when the one ahead is free, so input stays open while a
// finished result waits. The per-lane path is bounded by the 32 x 33 bit
// threshold multiply in stage three. Configuration is register 0 threshold
// (Q16.16) and register 1 epsilon; the user must write them only when idle,
// the block does not enforce it. Depends on tci_pkg, tci_lane and tci_merge.
`default_nettype none

module troubled_cell_indicator
  import tci_pkg::*;
#(
  parameter int unsigned COMPONENTS = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic        [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic        [THR_BITS-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic        [CELL_BITS-1:0]  cell_index_i,
  input  wire logic signed [VALUE_BITS-1:0] center_value_0_i,
  input  wire logic signed [VALUE_BITS-1:0] center_value_1_i,
  input  wire logic signed [VALUE_BITS-1:0] center_value_2_i,
  input  wire logic signed [VALUE_BITS-1:0] center_value_3_i,
  input  wire logic signed [VALUE_BITS-1:0] own_value_0_i,
  input  wire logic signed [VALUE_BITS-1:0] own_value_1_i,
  input  wire logic signed [VALUE_BITS-1:0] own_value_2_i,
  input  wire logic signed [VALUE_BITS-1:0] own_value_3_i,
  input  wire logic                         last_element_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic             [CELL_BITS-1:0]  result_cell_o,
  output logic                              troubled_o
);

  logic [THR_BITS-1:0] threshold_q;
  logic [EPS_BITS-1:0] epsilon_q;
  logic                first_q;
  logic                s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic                out_free, s3_move, s3_free, s2_move, s2_free, s1_move, s1_free;
  logic                accept;
  logic [CELL_BITS-1:0] s1_cell_q, s2_cell_q, s3_cell_q;
  logic signed [VALUE_BITS-1:0] cv_arr [MAX_COMPONENTS];
  logic signed [VALUE_BITS-1:0] ov_arr [MAX_COMPONENTS];
  logic [COMPONENTS-1:0] exceed;
  tci_ctrl_t            ctrl;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      epsilon_q   <= EPSILON_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: threshold_q <= cfg_wdata_i;
        CFG_EPSILON:   epsilon_q   <= cfg_wdata_i[EPS_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // Stage advance chain, collapsing bubbles
  always_comb begin
    out_free = !out_v_q || out_ready_i;
    s3_move  = s3_v_q && out_free;
    s3_free  = !s3_v_q || s3_move;
    s2_move  = s2_v_q && s3_free;
    s2_free  = !s2_v_q || s2_move;
    s1_move  = s1_v_q && s2_free;
    s1_free  = !s1_v_q || s1_move;
  end

  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && s1_free;

  assign ctrl.accept  = accept;
  assign ctrl.first   = first_q;
  assign ctrl.s1_load = accept && last_element_i;
  assign ctrl.s1_move = s1_move;
  assign ctrl.s2_move = s2_move;

  // Stage valids and stencil start flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        first_q <= last_element_i;
      end
      s1_v_q  <= ctrl.s1_load || (s1_v_q && !s1_move);
      s2_v_q  <= s1_move || (s2_v_q && !s2_move);
      s3_v_q  <= s2_move || (s3_v_q && !s3_move);
      out_v_q <= s3_move || (out_v_q && !out_ready_i);
    end
  end

  // Cell index rides along with the lane stages
  always_ff @(posedge clk_i) begin
    if (ctrl.s1_load) s1_cell_q <= cell_index_i;
    if (s1_move)      s2_cell_q <= s1_cell_q;
    if (s2_move)      s3_cell_q <= s2_cell_q;
  end

  assign cv_arr[0] = center_value_0_i;
  assign cv_arr[1] = center_value_1_i;
  assign cv_arr[2] = center_value_2_i;
  assign cv_arr[3] = center_value_3_i;
  assign ov_arr[0] = own_value_0_i;
  assign ov_arr[1] = own_value_1_i;
  assign ov_arr[2] = own_value_2_i;
  assign ov_arr[3] = own_value_3_i;

  // One lane per component
  for (genvar c = 0; c < COMPONENTS; c++) begin : g_lane
    tci_lane u_lane (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .threshold_i    (threshold_q),
      .epsilon_i      (epsilon_q),
      .center_value_i (cv_arr[c]),
      .own_value_i    (ov_arr[c]),
      .exceed_o       (exceed[c])
    );
  end

  tci_merge #(
    .COMPONENTS (COMPONENTS)
  ) u_merge (
    .clk_i         (clk_i),
    .load_i        (s3_move),
    .cell_i        (s3_cell_q),
    .exceed_i      (exceed),
    .result_cell_o (result_cell_o),
    .troubled_o    (troubled_o)
  );

  assign out_valid_o = out_v_q;

endmodule

`default_nettype wire

// ----- rtl/tci_checker.sv -----
// Port-level checker for the troubled cell indicator, bound to the top.
// Depends on tci_pkg and troubled_cell_indicator_macros.svh.
`default_nettype none

`include "troubled_cell_indicator_macros.svh"

module tci_checker
  import tci_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 last_element_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [CELL_BITS-1:0] result_cell_o,
  input wire logic                 troubled_o
);

  logic acc_last;
  assign acc_last = in_valid_i && in_ready_o && last_element_i;

  // A stalled result holds
  `TCI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(result_cell_o) && $stable(troubled_o))

  // Input only blocks when the whole chain is backed up by the output
  `TCI_ASSERT_IMPL(a_in_block, !in_ready_o, out_valid_o && !out_ready_i)

  // With out_ready_i held high while it passes the stages, a finished stencil shows up on the output
  `TCI_ASSERT_NEXT(a_latency,
    acc_last ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_o)

endmodule

bind troubled_cell_indicator tci_checker u_tci_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for troubled_cell_indicator: streams cell stencils,
// predicts each cell's troubled flag in-line and checks every result request.
// Depends on tci_pkg and the troubled_cell_indicator RTL only.

module testbench;
  import tci_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_CAP    = 200;

  typedef struct packed {
    logic [CELL_BITS-1:0]                       cell_id;
    logic [MAX_COMPONENTS-1:0][VALUE_BITS-1:0] center;
    logic [MAX_COMPONENTS-1:0][VALUE_BITS-1:0] own;
    logic                                       last;
  } element_t;

  typedef struct packed {
    logic [CELL_BITS-1:0] cell_id;
    logic                 troubled;
  } verdict_t;

  typedef enum int {STYLE_RANDOM, STYLE_EXTREME, STYLE_SMOOTH, STYLE_MIXED} stencil_style_e;

  // Clock, reset and block inputs, all known from time zero
  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         cfg_we_i         = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_index_i      = CFG_THRESHOLD;
  logic [THR_BITS-1:0]          cfg_wdata_i      = '0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_ready_o;
  logic [CELL_BITS-1:0]         cell_index_i     = '0;
  logic signed [VALUE_BITS-1:0] center_value_0_i = '0;
  logic signed [VALUE_BITS-1:0] center_value_1_i = '0;
  logic signed [VALUE_BITS-1:0] center_value_2_i = '0;
  logic signed [VALUE_BITS-1:0] center_value_3_i = '0;
  logic signed [VALUE_BITS-1:0] own_value_0_i    = '0;
  logic signed [VALUE_BITS-1:0] own_value_1_i    = '0;
  logic signed [VALUE_BITS-1:0] own_value_2_i    = '0;
  logic signed [VALUE_BITS-1:0] own_value_3_i    = '0;
  logic                         last_element_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i      = 1'b1;
  logic [CELL_BITS-1:0]         result_cell_o;
  logic                         troubled_o;

  // Predictor state: configuration plus per-component stencil accumulators
  logic [THR_BITS-1:0]                        ck_reg  = THRESHOLD_RESET;
  logic [EPS_BITS-1:0]                        eps_reg = EPSILON_RESET;
  logic [MAX_COMPONENTS-1:0][VALUE_BITS-1:0] anchor_center = '0;
  logic [MAX_COMPONENTS-1:0][SUM_BITS-1:0]   jump_total    = '0;
  logic [MAX_COMPONENTS-1:0][VALUE_BITS-1:0] peak_own      = '0;
  bit                                         at_stencil_start = 1'b1;

  verdict_t    expected_verdicts[$];
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;

  troubled_cell_indicator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cell_index_i    (cell_index_i),
    .center_value_0_i(center_value_0_i),
    .center_value_1_i(center_value_1_i),
    .center_value_2_i(center_value_2_i),
    .center_value_3_i(center_value_3_i),
    .own_value_0_i   (own_value_0_i),
    .own_value_1_i   (own_value_1_i),
    .own_value_2_i   (own_value_2_i),
    .own_value_3_i   (own_value_3_i),
    .last_element_i  (last_element_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_cell_o   (result_cell_o),
    .troubled_o      (troubled_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[troubled_cell_indicator] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [CELL_BITS-1:0] cell_id,
                                 input logic [31:0] got, input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("%0t: %s mismatch, cell %h: got %h, expected %h", $time, what, cell_id, got,
               want);
  endtask

  // Accumulate one stencil element; a last element yields the cell verdict
  function automatic void predict_element(input element_t e);
    logic [VALUE_BITS-1:0] cv, om, jump;
    logic [SUM_BITS:0]     total;
    logic [VALUE_BITS:0]   guarded;
    logic [71:0]           lhs, rhs;
    bit                    hot;
    verdict_t              v;
    int                    c;
    hot = 1'b0;
    for (c = 0; c < MAX_COMPONENTS; c++) begin
      // offset binary keeps signed order as unsigned order
      cv = e.center[c] ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
      om = e.own[c][VALUE_BITS-1] ? (~e.own[c] + 1'b1) : e.own[c];
      if (at_stencil_start) begin
        anchor_center[c] = cv;
        jump_total[c]    = '0;
        peak_own[c]      = om;
      end else begin
        jump = (anchor_center[c] > cv) ? anchor_center[c] - cv : cv - anchor_center[c];
        total = {1'b0, jump_total[c]} + (SUM_BITS+1)'(jump);
        jump_total[c] = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
        if (om > peak_own[c]) peak_own[c] = om;
      end
    end
    at_stencil_start = e.last;
    if (e.last) begin
      // sum / (max + eps) > Ck, cross-multiplied at full width
      for (c = 0; c < MAX_COMPONENTS; c++) begin
        guarded = {1'b0, peak_own[c]} + (VALUE_BITS+1)'(eps_reg);
        lhs = {16'b0, jump_total[c], 16'b0};
        rhs = 72'(ck_reg) * 72'(guarded);
        if (lhs > rhs) hot = 1'b1;
      end
      v.cell_id  = e.cell_id;
      v.troubled = hot;
      expected_verdicts = {expected_verdicts, v};
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result", result_cell_o, 32'(troubled_o), 32'd0);
      end else begin
        want = expected_verdicts.pop_front();
        if (result_cell_o !== want.cell_id)
          report_mismatch("result_cell", want.cell_id, 32'(result_cell_o),
                          32'(want.cell_id));
        if (troubled_o !== want.troubled)
          report_mismatch("troubled", want.cell_id, 32'(troubled_o), 32'(want.troubled));
      end
    end
  end

  // Receiver stalls in bursts
  initial begin : sink_pacing
    forever begin
      @(posedge clk_i);
      if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Send one element request; returns at the accepting edge with valid still high
  task automatic send_element(input element_t e);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    cell_index_i     <= e.cell_id;
    center_value_0_i <= e.center[0];
    center_value_1_i <= e.center[1];
    center_value_2_i <= e.center[2];
    center_value_3_i <= e.center[3];
    own_value_0_i    <= e.own[0];
    own_value_1_i    <= e.own[1];
    own_value_2_i    <= e.own[2];
    own_value_3_i    <= e.own[3];
    last_element_i   <= e.last;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_element(e);
  endtask

  // Same value in all four components
  task automatic send_uniform(input logic [CELL_BITS-1:0] cell_id,
                              input logic [VALUE_BITS-1:0] cv,
                              input logic [VALUE_BITS-1:0] ov, input logic last);
    element_t e;
    e.cell_id = cell_id;
    e.center  = {MAX_COMPONENTS{cv}};
    e.own     = {MAX_COMPONENTS{ov}};
    e.last    = last;
    send_element(e);
  endtask

  // Drop valid and wait until every expected result came and the pipe is empty
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [THR_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_THRESHOLD) ck_reg = data;
    else eps_reg = data[EPS_BITS-1:0];
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [THR_BITS-1:0] thr, input logic [EPS_BITS-1:0] eps);
    settle_pipeline();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_EPSILON, THR_BITS'(eps));
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(input stencil_style_e style,
                                                       input logic [VALUE_BITS-1:0] base,
                                                       input int unsigned spread);
    logic [VALUE_BITS-1:0] v;
    stencil_style_e        s;
    s = style;
    if (s == STYLE_MIXED) s = stencil_style_e'($urandom_range(0, 2));
    case (s)
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '0;
          3:       v = '1;
          default: v = 32'd1;
        endcase
      end
      STYLE_SMOOTH: v = base + $urandom_range(0, 2 * spread) - spread;
      default:      v = $urandom;
    endcase
    return v;
  endfunction

  // One closed stencil of random content; smooth data dominates
  task automatic send_stencil(input int len);
    element_t                                   e;
    logic [CELL_BITS-1:0]                       stencil_id;
    logic [MAX_COMPONENTS-1:0][VALUE_BITS-1:0] base;
    int unsigned                                spread;
    int unsigned                                sel;
    stencil_style_e                             style;
    int                                         k, c;
    stencil_id = CELL_BITS'($urandom);
    spread     = 1 << $urandom_range(0, 16);
    sel        = $urandom_range(0, 7);
    style      = (sel < 4) ? STYLE_SMOOTH : (sel < 6) ? STYLE_RANDOM :
                 (sel == 6) ? STYLE_EXTREME : STYLE_MIXED;
    for (c = 0; c < MAX_COMPONENTS; c++) begin
      base[c] = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 1)) base[c] = -base[c];
    end
    for (k = 0; k < len; k++) begin
      // the result carries the last element's index, so vary it now and then
      e.cell_id = (k == len - 1 && $urandom_range(0, 7) == 0) ? CELL_BITS'($urandom) :
                  stencil_id;
      for (c = 0; c < MAX_COMPONENTS; c++) begin
        e.center[c] = pick_value(style, base[c], spread);
        e.own[c]    = pick_value(style, base[c], spread);
      end
      e.last = (k == len - 1);
      send_element(e);
    end
  endtask

  function automatic int pick_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
  endfunction

  // Field extremes, single-element stencils and the exact comparison boundary
  task automatic test_directed_extremes();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_uniform(16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_uniform(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // full-range jump against the most negative own value
    send_uniform(16'h5A5A, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_uniform(16'h5A5A, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // flat stencil, index changes on the last element
    send_uniform(16'h1111, 32'hDEAD_0000, 32'hFFFF_0000, 1'b0);
    send_uniform(16'h1111, 32'hDEAD_0000, 32'hFFFF_0000, 1'b0);
    send_uniform(16'h2222, 32'hDEAD_0000, 32'hFFFF_0000, 1'b1);
    // sum equal to Ck*(max+eps): not troubled; one more LSB: troubled
    send_uniform(16'h0100, 32'h0000_0000, 32'h0000_1234, 1'b0);
    send_uniform(16'h0100, 32'h0000_1235, 32'hFFFF_EDCC, 1'b1);
    send_uniform(16'h0101, 32'h0000_0000, 32'h0000_1234, 1'b0);
    send_uniform(16'h0101, 32'h0000_1236, 32'hFFFF_EDCC, 1'b1);
    // negative jumps
    send_uniform(16'hA5A5, 32'h0000_0000, 32'h0001_0000, 1'b0);
    send_uniform(16'hA5A5, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
    send_uniform(16'hA5A5, 32'hFFFE_0000, 32'h0001_0000, 1'b1);
  endtask

  // Zero max with zero epsilon, and a zero threshold
  task automatic test_zero_guard();
    apply_config(32'h0001_0000, 16'h0000);
    send_uniform(16'h0200, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_uniform(16'h0200, 32'h0000_0001, 32'h0000_0000, 1'b1);
    send_uniform(16'h0201, 32'h0000_0005, 32'h0000_0000, 1'b0);
    send_uniform(16'h0201, 32'h0000_0005, 32'h0000_0000, 1'b1);
    apply_config(32'h0000_0000, 16'h0000);
    send_uniform(16'h0202, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    send_uniform(16'h0202, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1);
    send_uniform(16'h0203, 32'h1234_5678, 32'h0000_0000, 1'b1);
  endtask

  // Stencils far longer than the neighbour count drive the sums into saturation
  task automatic test_saturation();
    int k;
    apply_config(THRESHOLD_RESET, EPSILON_RESET);
    send_uniform(16'h0300, 32'h8000_0000, 32'h0000_0000, 1'b0);
    for (k = 1; k < 260; k++)
      send_uniform(16'h0300, 32'h7FFF_FFFF, 32'h0000_0000, k == 259);
    // Ck*(max+eps) sits just above the saturated sum but below the true one
    apply_config(32'hFFFF_FFFF, 16'h0001);
    send_uniform(16'h0301, 32'h8000_0000, 32'h0100_0000, 1'b0);
    for (k = 1; k < 260; k++)
      send_uniform(16'h0301, 32'h7FFF_FFFF, 32'hFF00_0000, k == 259);
  endtask

  // Random stencils under several configurations, extremes included
  task automatic test_random_stencils();
    logic [THR_BITS-1:0] thr_set[6];
    logic [EPS_BITS-1:0] eps_set[6];
    int                  p, sent, len;
    thr_set = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000,
                32'h0004_0000, 32'h0000_0000};
    eps_set = '{16'h0001, 16'h0000, 16'hFFFF, 16'h0100, 16'h0000, 16'h0000};
    thr_set[5] = $urandom_range(0, 32'h0010_0000);
    eps_set[5] = EPS_BITS'($urandom_range(0, 16'hFFFF));
    for (p = 0; p < 6; p++) begin
      apply_config(thr_set[p], eps_set[p]);
      src_idle_on  = (p != 2);
      sink_idle_on = (p != 3);
      sent = 0;
      while (sent < 100) begin
        len = pick_length();
        send_stencil(len);
        sent += len;
      end
    end
  endtask

  // Sender holds off until every outstanding result has come back
  task automatic test_drain_pause();
    int r;
    apply_config(THRESHOLD_RESET, EPSILON_RESET);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (r = 0; r < 4; r++) begin
      send_stencil(pick_length());
      send_stencil(pick_length());
      settle_pipeline();
    end
  endtask

  // Last stretch: no gaps on either side
  task automatic test_back_to_back();
    int sent, len;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    sent = 0;
    while (sent < 130) begin
      len = pick_length();
      send_stencil(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_zero_guard();
    test_saturation();
    test_random_stencils();
    test_drain_pause();
    test_back_to_back();
    settle_pipeline();
    if (error_count == 0)
      $display("[troubled_cell_indicator] OK");
    else
      $display("[troubled_cell_indicator] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tci_pkg.sv
rtl/tci_lane.sv
rtl/tci_merge.sv
rtl/troubled_cell_indicator.sv
rtl/tci_checker.sv
test/testbench.sv
